// File: sv/kst_pkg.sv
// Shared constants and types for the k-th smallest tracker.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package kst_pkg;

    // Fixed data width of the streamed values
    localparam int DATA_W = 32;

    // Width of the rank register and its value after reset
    localparam int RANK_W = 5;
    localparam logic [RANK_W-1:0] RANK_K_RESET = 5'd2;

    // Default bound on the number of retained values
    localparam int K_MAX_DEFAULT = 16;

    // Result handed from the sorted store to the result register
    typedef struct packed {
        logic signed [DATA_W-1:0] kth_value;
        logic                     full_res;
    } result_t;

endpackage

// File: sv/kst_in_if.sv
// Input channel of the k-th smallest tracker: valid/ready plus one value.
// Depends on kst_pkg for the data width.
`timescale 1ns / 1ps

interface kst_in_if;

    logic                              valid;
    logic                              ready;
    logic signed [kst_pkg::DATA_W-1:0] value;
    logic                              first;

    modport source (output valid, output value, output first, input ready);
    modport sink   (input valid, input value, input first, output ready);

endinterface

// File: sv/kst_out_if.sv
// Result channel of the k-th smallest tracker: valid/ready plus one result.
// Depends on kst_pkg for the data width.
`timescale 1ns / 1ps

interface kst_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [kst_pkg::DATA_W-1:0] kth_value;
    logic                              full_res;

    modport source (output valid, output kth_value, output full_res, input ready);
    modport sink   (input valid, input kth_value, input full_res, output ready);

endinterface

// File: sv/kst_sort_array.sv
// Sorted register array holding the smallest values of the current set.
// Inserts one value per update with parallel compares; depends on kst_pkg.
`timescale 1ns / 1ps

module kst_sort_array #(
    parameter int K_MAX = kst_pkg::K_MAX_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              upd,
    input  logic signed [kst_pkg::DATA_W-1:0] value,
    input  logic                              first,
    input  logic [$clog2(K_MAX+1)-1:0]        rank_eff,
    output kst_pkg::result_t                  result_next
);

    localparam int CW = $clog2(K_MAX + 1);
    localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    logic signed [kst_pkg::DATA_W-1:0] kept_reg  [K_MAX];
    logic signed [kst_pkg::DATA_W-1:0] kept_next [K_MAX];
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [CW-1:0]                     cnt_cur;
    logic [CW-1:0]                     cnt_inc;
    logic [CW-1:0]                     cnt_last;
    logic [K_MAX-1:0]                  le;

    // A first-flagged item starts from an empty set
    assign cnt_cur = first ? '0 : count_reg;

    // Entries that stay in place: valid and not greater than the new value
    always_comb
    begin
        for (int i = 0; i < K_MAX; i++)
        begin
            le[i] = (i < int'(cnt_cur)) && (kept_reg[i] <= value);
        end
    end

    // Keep, insert or shift up by one, per entry
    always_comb
    begin
        kept_next[0] = le[0] ? kept_reg[0] : value;
        for (int i = 1; i < K_MAX; i++)
        begin
            if (le[i])
                kept_next[i] = kept_reg[i];
            else if (le[i-1])
                kept_next[i] = value;
            else
                kept_next[i] = kept_reg[i-1];
        end
    end

    // New fill level, cut to the effective rank
    assign cnt_inc    = (cnt_cur < CW'(K_MAX)) ? cnt_cur + CW'(1) : cnt_cur;
    assign count_next = (cnt_inc > rank_eff) ? rank_eff : cnt_inc;
    assign cnt_last   = count_next - CW'(1);

    // Largest retained value after the insertion
    assign result_next.kth_value = kept_next[cnt_last[IW-1:0]];
    assign result_next.full_res  = (count_next == rank_eff);

    // Fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (upd)
            count_reg <= count_next;
    end

    // Stored values, no reset: only entries below the fill level are read
    always_ff @(posedge clk)
    begin
        if (upd)
            kept_reg <= kept_next;
    end

endmodule

// File: sv/kth_smallest_tracker.sv
// Top level of the k-th smallest tracker: channel registers, rank register.
// Depends on kst_pkg, kst_in_if, kst_out_if and kst_sort_array.
`timescale 1ns / 1ps

// Usage
//   in_ch  : transfers of {value, first}; first = 1 clears the retained set
//            before value is inserted.
//   out_ch : one transfer per input item, {kth_value, full_res}: the largest
//            retained value and whether rank_k values are held.
//   cfg_we / cfg_wdata : write of rank_k, taken at any edge with cfg_we high;
//            the user writes only while the block is idle, which the block does
//            not enforce. 0 acts as 1, above K_MAX as K_MAX.
// Path: a result passes the input register, then the result register, with
//   the sorted array updated on the same edge as the result register.
// Throughput: one item per cycle while out_ch.ready is high; the array
//   compares every stored entry in parallel and accepts a value each clock.
// Reset: the retained set is empty, rank_k is 2, both channels are idle.
// Stall: while out_ch.ready is low the result is held; the input register
//   takes one more item and then in_ch.ready drops until the result moves.

module kth_smallest_tracker #(
    parameter int K_MAX = kst_pkg::K_MAX_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    kst_in_if.sink                      in_ch,
    kst_out_if.source                   out_ch,
    input  logic                        cfg_we,
    input  logic [kst_pkg::RANK_W-1:0]  cfg_wdata
);

    localparam int CW = $clog2(K_MAX + 1);

    logic [kst_pkg::RANK_W-1:0]        rank_k_reg;
    logic [CW-1:0]                     rank_eff;
    logic signed [kst_pkg::DATA_W-1:0] in_value_reg;
    logic                              in_first_reg;
    logic                              in_valid_reg;
    logic                              res_valid_reg;
    kst_pkg::result_t                  res_reg;
    kst_pkg::result_t                  res_next;
    logic                              advance;
    logic                              in_xfer;

    // Rank register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rank_k_reg <= kst_pkg::RANK_K_RESET;
        else if (cfg_we)
            rank_k_reg <= cfg_wdata;
    end

    // Clamp the rank into 1 .. K_MAX
    always_comb
    begin
        if (rank_k_reg == '0)
            rank_eff = CW'(1);
        else if (int'(rank_k_reg) > K_MAX)
            rank_eff = CW'(K_MAX);
        else
            rank_eff = CW'(rank_k_reg);
    end

    // Handshake: the held item moves on when the result slot is free or drains
    assign advance      = in_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign in_xfer      = in_ch.valid && in_ch.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_value_reg <= in_ch.value;
            in_first_reg <= in_ch.first;
        end
    end

    // Sorted store and insertion
    kst_sort_array #(
        .K_MAX (K_MAX)
    ) u_sort (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (advance),
        .value       (in_value_reg),
        .first       (in_first_reg),
        .rank_eff    (rank_eff),
        .result_next (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (out_ch.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid     = res_valid_reg;
    assign out_ch.kth_value = res_reg.kth_value;
    assign out_ch.full_res  = res_reg.full_res;

endmodule

// File: bench/kth_smallest_tracker_tb.sv
// Self-checking bench for kth_smallest_tracker: random valid/ready traffic on both
// channels, an in-bench sorted-store predictor and an in-order result scoreboard.
// Depends on kst_pkg, kst_in_if, kst_out_if and the RTL of the tracker.
`timescale 1ns / 1ps

module kth_smallest_tracker_tb;

    localparam int K_MAX       = kst_pkg::K_MAX_DEFAULT;
    localparam int QUIET_LIMIT = 500;
    localparam int PHASES      = 20;

    localparam logic signed [kst_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [kst_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [kst_pkg::DATA_W-1:0] value;
        logic                              first;
    } sample_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [kst_pkg::RANK_W-1:0] cfg_wdata;

    kst_in_if  in_ch ();
    kst_out_if out_ch ();

    kth_smallest_tracker #(
        .K_MAX (K_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Pending input samples and expected results
    sample_t          pending_samples[$];
    kst_pkg::result_t expected_kth_q[$];

    // Mirror of the retained set and the rank register
    logic signed [kst_pkg::DATA_W-1:0] kept_vals [K_MAX];
    int                                kept_count;
    logic [kst_pkg::RANK_W-1:0]        rank_mirror;

    int               fail_count = 0;
    int               quiet_cycles;
    int               feed_wait;
    int               sink_wait;
    int               stall_draw;
    bit               no_idle = 1'b0;
    sample_t          next_sample;
    kst_pkg::result_t got_exp;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Insert one value into the mirrored sorted store, return largest retained + full
    function automatic kst_pkg::result_t insert_and_rank(
        logic signed [kst_pkg::DATA_W-1:0] v,
        logic                              first_flag
    );
        int               k;
        int               pos;
        int               top;
        kst_pkg::result_t r;
        k = int'(rank_mirror);
        if (k < 1)
            k = 1;
        if (k > K_MAX)
            k = K_MAX;
        if (first_flag)
            kept_count = 0;
        pos = 0;
        // equal values go after those already held
        while (pos < kept_count && kept_vals[pos] <= v)
            pos++;
        if (pos < K_MAX)
        begin
            top = (kept_count < K_MAX) ? kept_count : K_MAX - 1;
            for (int i = top; i > pos; i--)
                kept_vals[i] = kept_vals[i - 1];
            kept_vals[pos] = v;
            if (kept_count < K_MAX)
                kept_count++;
        end
        // a lowered rank trims the largest values here
        if (kept_count > k)
            kept_count = k;
        r.kth_value = (kept_count > 0) ? kept_vals[kept_count - 1] : '0;
        r.full_res  = (kept_count == k);
        return r;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Mix of extremes, a narrow band (plenty of ties) and full-range values
    function automatic logic signed [kst_pkg::DATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return int'($urandom_range(0, 16)) - 8;
            5:       return VAL_MIN + int'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic push_sample(logic signed [kst_pkg::DATA_W-1:0] v, logic first_flag);
        sample_t s;
        s.value = v;
        s.first = first_flag;
        pending_samples.push_back(s);
    endtask

    // Wait until every transfer has gone through and the result channel is empty
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_ch.valid || out_ch.valid
               || expected_kth_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_rank(logic [kst_pkg::RANK_W-1:0] r);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Input driver and predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
            in_ch.first <= 1'b0;
            feed_wait   <= 0;
            kept_count  = 0;
            rank_mirror = kst_pkg::RANK_K_RESET;
        end
        else
        begin
            if (cfg_we)
                rank_mirror = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                expected_kth_q.push_back(insert_and_rank(in_ch.value, in_ch.first));
            // slot is free once the current transfer has gone
            if (!in_ch.valid || in_ch.ready)
            begin
                if (feed_wait > 0)
                begin
                    feed_wait   <= feed_wait - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    next_sample = pending_samples.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.value <= next_sample.value;
                    in_ch.first <= next_sample.first;
                    feed_wait   <= draw_gap();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_wait    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_kth_q.size() == 0)
                begin
                    $error("unexpected result: kth_value %0d full_res %0b",
                           out_ch.kth_value, out_ch.full_res);
                    fail_count++;
                end
                else
                begin
                    got_exp = expected_kth_q.pop_front();
                    if (out_ch.kth_value !== got_exp.kth_value)
                    begin
                        $error("kth_value mismatch: expected %0d, actual %0d",
                               got_exp.kth_value, out_ch.kth_value);
                        fail_count++;
                    end
                    if (out_ch.full_res !== got_exp.full_res)
                    begin
                        $error("full_res mismatch: expected %0b, actual %0b",
                               got_exp.full_res, out_ch.full_res);
                        fail_count++;
                    end
                end
                stall_draw = draw_gap();
                sink_wait    <= stall_draw;
                out_ch.ready <= (stall_draw == 0);
            end
            else if (sink_wait > 0)
            begin
                sink_wait    <= sink_wait - 1;
                out_ch.ready <= (sink_wait == 1);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        int                         n_items;
        bit                         fresh;
        logic [kst_pkg::RANK_W-1:0] rank_sel;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rank of two: extremes, ties, a fresh set
        push_sample(5, 1'b1);
        push_sample(5, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(VAL_MAX, 1'b0);
        push_sample(VAL_MIN, 1'b0);
        push_sample(0, 1'b1);
        push_sample(-1, 1'b0);
        push_sample(-1, 1'b0);

        // rank zero behaves as one, lowered without a new set
        write_rank(5'd0);
        push_sample(7, 1'b0);
        push_sample(VAL_MAX, 1'b1);
        push_sample(3, 1'b0);

        // rank above the bound behaves as the bound, raised mid-set
        write_rank(5'd31);
        push_sample(32'sh5555_5555, 1'b0);
        push_sample(32'shAAAA_AAAA, 1'b0);
        push_sample(VAL_MIN, 1'b0);
        push_sample(VAL_MAX, 1'b0);
        for (int i = 0; i < 8; i++)
            push_sample(32'sh0123_4567 * (i + 1) - 32'sh3000_0000 * i, 1'b0);

        // random phases over a spread of rank settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 6)
                0:       rank_sel = 5'd1;
                1:       rank_sel = 5'd16;
                2:       rank_sel = 5'd0;
                3:       rank_sel = 5'd31;
                4:       rank_sel = 5'd17;
                default: rank_sel = kst_pkg::RANK_W'($urandom_range(0, 31));
            endcase
            write_rank(rank_sel);
            no_idle = ($urandom_range(0, 3) == 0);
            fresh   = ($urandom_range(0, 2) != 0);
            n_items = $urandom_range(60, 140);
            for (int i = 0; i < n_items; i++)
                push_sample(draw_value(), (i == 0 && fresh) || ($urandom_range(0, 24) == 0));
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && expected_kth_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
sv/kst_pkg.sv
sv/kst_in_if.sv
sv/kst_out_if.sv
sv/kst_sort_array.sv
sv/kth_smallest_tracker.sv
bench/kth_smallest_tracker_tb.sv
